### hw/rtl/mcrq_pkg.sv
// ----------------------------------------------------------------------------
// mcrq_pkg: shared types and codes of the multi-CPU ready-queue scheduler
// Holds the operation, mode, kind and register codes, the FSM state type and
// the structs that travel between the top level and its queue and CPU cells.
// ----------------------------------------------------------------------------
`default_nettype none

package mcrq_pkg;

    // Default sizes
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NUM_CPUS_DEF    = 16;

    // A CPU running at or above this priority is never asked to preempt
    localparam logic [3:0] PRIO_CEILING = 4'd11;

    // Event codes
    localparam logic [2:0] OP_WAKE      = 3'd0;
    localparam logic [2:0] OP_PREEMPT   = 3'd1;
    localparam logic [2:0] OP_YIELD     = 3'd2;
    localparam logic [2:0] OP_TERMINATE = 3'd3;
    localparam logic [2:0] OP_IDLE_REQ  = 3'd4;

    // Queue ordering modes (codes two and three are both round robin)
    localparam logic [1:0] MODE_PID  = 2'd0;
    localparam logic [1:0] MODE_PRIO = 2'd1;
    localparam logic [1:0] MODE_RR   = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_DISPATCH = 2'd1;
    localparam logic [1:0] KIND_PREEMPT  = 2'd2;

    // State of a process leaving its CPU
    localparam logic [1:0] LEAVE_NONE       = 2'd0;
    localparam logic [1:0] LEAVE_WAITING    = 2'd1;
    localparam logic [1:0] LEAVE_TERMINATED = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE       = 2'd0;
    localparam logic [1:0] CFG_TIME_SLICE = 2'd1;
    localparam logic [1:0] CFG_CPU_COUNT  = 2'd2;

    // Register reset values
    localparam logic [1:0] MODE_RESET       = MODE_PID;
    localparam logic [7:0] TIME_SLICE_RESET = 8'd10;
    localparam logic [4:0] CPU_COUNT_RESET  = 5'd1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_SCAN,
        ST_DISPATCH,
        ST_EMIT
    } sched_state_t;

    // One ready-queue slot; occ marks slots below the fill level
    typedef struct packed {
        logic       occ;
        logic [7:0] pid;
        logic [3:0] prio;
    } q_entry_t;

    // Command broadcast to every queue cell
    typedef struct packed {
        logic       insert;
        logic       pop;
        logic [1:0] mode;
        logic [7:0] pid;
        logic [3:0] prio;
    } q_cmd_t;

    // Running-process record of one CPU
    typedef struct packed {
        logic       busy;
        logic [7:0] pid;
        logic [3:0] prio;
    } cpu_entry_t;

    // Preemption search token passed from CPU cell to CPU cell
    typedef struct packed {
        logic       idle_seen;
        logic       found;
        logic [3:0] lowest;
        logic [3:0] victim;
    } scan_tok_t;

    // One result word
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] target_cpu;
        logic [7:0] run_pid;
        logic       run_idle;
        logic       slice_limited;
        logic [7:0] slice_length;
        logic [7:0] leaving_pid;
        logic [1:0] leaving_state;
        logic       queue_overflow;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/mcrq_queue_cell.sv
// ----------------------------------------------------------------------------
// mcrq_queue_cell: one slot of the ready queue
// Holds one (pid, priority) entry. On insert, slots ahead of the insertion
// point hold, the slot at it takes the newcomer and slots behind it take
// their left neighbor. On pop every slot takes its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrq_queue_cell (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire mcrq_pkg::q_cmd_t    cmd,
    input  wire mcrq_pkg::q_entry_t  left,
    input  wire                      seen_in,
    input  wire mcrq_pkg::q_entry_t  right,
    output mcrq_pkg::q_entry_t       entry,
    output logic                     seen_out
);

    logic       occ_reg;
    logic       occ_next;
    logic [7:0] pid_reg;
    logic [7:0] pid_next;
    logic [3:0] prio_reg;
    logic [3:0] prio_next;
    logic       match;
    logic       hit;

    // Newcomer goes ahead of this entry
    always_comb
    begin
        case (cmd.mode)
            mcrq_pkg::MODE_PID:  match = (pid_reg > cmd.pid);
            mcrq_pkg::MODE_PRIO: match = (prio_reg <= cmd.prio);
            default:             match = 1'b0;
        endcase
    end

    // An empty slot always stops the search
    assign hit      = !occ_reg || match;
    assign seen_out = seen_in || hit;

    // Shift / insert selection
    always_comb
    begin
        occ_next  = occ_reg;
        pid_next  = pid_reg;
        prio_next = prio_reg;
        if (cmd.insert)
        begin
            if (seen_in)
            begin
                occ_next  = left.occ;
                pid_next  = left.pid;
                prio_next = left.prio;
            end
            else if (hit)
            begin
                occ_next  = 1'b1;
                pid_next  = cmd.pid;
                prio_next = cmd.prio;
            end
        end
        else if (cmd.pop)
        begin
            occ_next  = right.occ;
            pid_next  = right.pid;
            prio_next = right.prio;
        end
    end

    // Fill marker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        pid_reg  <= pid_next;
        prio_reg <= prio_next;
    end

    assign entry.occ  = occ_reg;
    assign entry.pid  = pid_reg;
    assign entry.prio = prio_reg;

endmodule

`default_nettype wire

### hw/rtl/mcrq_cpu_cell.sv
// ----------------------------------------------------------------------------
// mcrq_cpu_cell: running-process record of one CPU
// Holds busy flag, pid and priority of the process on this CPU, and one stage
// of the preemption search: the token from the left neighbor is updated with
// this CPU and registered for the right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrq_cpu_cell #(
    parameter int INDEX = 0
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        wr_sel,
    input  wire mcrq_pkg::cpu_entry_t  wr_data,
    input  wire  [4:0]                 cpus_used,
    input  wire  [3:0]                 new_prio,
    input  wire mcrq_pkg::scan_tok_t   tok_in,
    output mcrq_pkg::scan_tok_t        tok_out,
    output mcrq_pkg::cpu_entry_t       entry
);

    logic                busy_reg;
    logic [7:0]          pid_reg;
    logic [3:0]          prio_reg;
    mcrq_pkg::scan_tok_t tok_reg;
    mcrq_pkg::scan_tok_t tok_next;
    logic                in_use;

    assign in_use = (int'(cpus_used) > INDEX);

    // Search step: stop at the first idle CPU, else track the lowest victim
    always_comb
    begin
        tok_next = tok_in;
        if (in_use && !tok_in.idle_seen)
        begin
            if (!busy_reg)
            begin
                tok_next.idle_seen = 1'b1;
            end
            else if ((new_prio > prio_reg) && (prio_reg < tok_in.lowest))
            begin
                tok_next.lowest = prio_reg;
                tok_next.victim = 4'(INDEX);
                tok_next.found  = 1'b1;
            end
        end
    end

    // Busy flag and search stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (wr_sel)
            begin
                busy_reg <= wr_data.busy;
            end
        end
    end

    // Running process, meaningful only while busy
    always_ff @(posedge clk)
    begin
        if (wr_sel)
        begin
            pid_reg  <= wr_data.pid;
            prio_reg <= wr_data.prio;
        end
    end

    assign tok_out    = tok_reg;
    assign entry.busy = busy_reg;
    assign entry.pid  = pid_reg;
    assign entry.prio = prio_reg;

endmodule

`default_nettype wire

### hw/rtl/multi_cpu_ready_queue_scheduler.sv
// ----------------------------------------------------------------------------
// multi_cpu_ready_queue_scheduler: ready queue and per-CPU dispatch control
// Sequencer around a row of queue cells and a row of CPU cells.
// ----------------------------------------------------------------------------
// One event word is taken at a time and gives exactly one result word. The
// event is taken in ST_IDLE, each queue operation (insert or pop) runs in the
// queue cell row, and ST_EMIT moves the result into the output register. An
// out-of-range or unknown event goes straight to ST_EMIT; yield, terminate,
// idle request and preempt of an idle CPU pass ST_DISPATCH; a wake-up outside
// priority mode or into a full queue passes ST_INSERT; preempt of a busy CPU
// passes ST_INSERT and ST_DISPATCH. A wake-up in priority mode that finds room
// passes ST_INSERT and runs the preemption search through the chain of CPU
// cells in ST_SCAN, one cell per cycle. The next event is taken as soon as the
// result sits in the output register, even if unread; while an earlier result
// is unread, the event waits in ST_EMIT. Configuration must be written only
// while no event is in progress; the user sees to this, the block does not.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_cpu_ready_queue_scheduler #(
    parameter int QUEUE_DEPTH = mcrq_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_CPUS    = mcrq_pkg::NUM_CPUS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    // Event stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // cpu[3:0], pid[11:4], priority_req[15:12]
    input  wire  [2:0]  s_tuser,   // op[2:0]
    // Result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // target_cpu[3:0], run_pid[11:4],
                                   // run_idle[12], slice_limited[13],
                                   // slice_length[21:14], leaving_pid[29:22],
                                   // leaving_state[31:30], queue_overflow[32],
                                   // zero[39:33]
    output logic [1:0]  m_tuser,   // kind[1:0]
    // Configuration write
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [7:0]  cfg_data
);

    localparam int CIDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int SCAN_W = $clog2(NUM_CPUS + 1);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    mcrq_pkg::sched_state_t state_reg;
    mcrq_pkg::sched_state_t state_next;

    logic [1:0]          mode_reg;
    logic [7:0]          slice_reg;
    logic [4:0]          cpu_count_reg;
    logic [4:0]          cpus_used;

    logic [2:0]          op_reg;
    logic [3:0]          cpu_reg;
    logic [CIDX_W-1:0]   cidx_reg;
    logic [7:0]          ins_pid_reg;
    logic [3:0]          ins_prio_reg;
    logic [SCAN_W-1:0]   scan_cnt_reg;
    mcrq_pkg::result_t   res_reg;
    mcrq_pkg::result_t   res_start;
    mcrq_pkg::result_t   m_res_reg;
    logic                m_valid_reg;

    logic [2:0]          in_op;
    logic [3:0]          in_cpu;
    logic [7:0]          in_pid;
    logic [3:0]          in_prio;
    logic [CIDX_W-1:0]   in_cidx;
    logic                in_accept;
    logic                in_cpu_ok;
    mcrq_pkg::cpu_entry_t in_cur;

    logic                out_free;
    logic                scan_done;

    mcrq_pkg::q_cmd_t    q_cmd;
    mcrq_pkg::q_entry_t  q_ent   [QUEUE_DEPTH];
    mcrq_pkg::q_entry_t  q_left  [QUEUE_DEPTH];
    mcrq_pkg::q_entry_t  q_right [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0] q_seen;
    logic                q_full;
    logic                q_empty;

    mcrq_pkg::cpu_entry_t cpu_ent [NUM_CPUS];
    mcrq_pkg::scan_tok_t  tok     [NUM_CPUS+1];
    mcrq_pkg::cpu_entry_t cpu_wr_data;
    logic                 cpu_wr_en;
    logic [NUM_CPUS-1:0]  cpu_wr_sel;

    // ------------------------------------------------------------------
    // Port unpacking and event decode
    // ------------------------------------------------------------------
    assign in_op     = s_tuser;
    assign in_cpu    = s_tdata[3:0];
    assign in_pid    = s_tdata[11:4];
    assign in_prio   = s_tdata[15:12];
    assign in_cidx   = CIDX_W'(in_cpu);
    assign in_accept = s_tvalid && s_tready;
    assign cpus_used = (int'(cpu_count_reg) > NUM_CPUS) ? 5'(NUM_CPUS) : cpu_count_reg;
    assign in_cpu_ok = ({1'b0, in_cpu} < cpus_used);
    assign in_cur    = cpu_ent[in_cidx];

    assign out_free  = !m_valid_reg || m_tready;
    assign scan_done = (scan_cnt_reg == SCAN_W'(NUM_CPUS));
    assign q_full    = q_ent[QUEUE_DEPTH-1].occ;
    assign q_empty   = !q_ent[0].occ;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= mcrq_pkg::MODE_RESET;
            slice_reg     <= mcrq_pkg::TIME_SLICE_RESET;
            cpu_count_reg <= mcrq_pkg::CPU_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mcrq_pkg::CFG_MODE:       mode_reg      <= cfg_data[1:0];
                mcrq_pkg::CFG_TIME_SLICE: slice_reg     <= cfg_data;
                mcrq_pkg::CFG_CPU_COUNT:  cpu_count_reg <= cfg_data[4:0];
                default:                  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mcrq_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (in_op) inside
                        mcrq_pkg::OP_WAKE:
                            state_next = mcrq_pkg::ST_INSERT;
                        mcrq_pkg::OP_PREEMPT:
                        begin
                            if (!in_cpu_ok)
                                state_next = mcrq_pkg::ST_EMIT;
                            else if (in_cur.busy)
                                state_next = mcrq_pkg::ST_INSERT;
                            else
                                state_next = mcrq_pkg::ST_DISPATCH;
                        end
                        mcrq_pkg::OP_YIELD, mcrq_pkg::OP_TERMINATE, mcrq_pkg::OP_IDLE_REQ:
                            state_next = in_cpu_ok ? mcrq_pkg::ST_DISPATCH
                                                   : mcrq_pkg::ST_EMIT;
                        default:
                            state_next = mcrq_pkg::ST_EMIT;
                    endcase
                end
            end
            mcrq_pkg::ST_INSERT:
            begin
                if (op_reg != mcrq_pkg::OP_WAKE)
                    state_next = mcrq_pkg::ST_DISPATCH;
                else if (!q_full && (mode_reg == mcrq_pkg::MODE_PRIO))
                    state_next = mcrq_pkg::ST_SCAN;
                else
                    state_next = mcrq_pkg::ST_EMIT;
            end
            mcrq_pkg::ST_SCAN:
            begin
                if (scan_done)
                    state_next = mcrq_pkg::ST_EMIT;
            end
            mcrq_pkg::ST_DISPATCH:
                state_next = mcrq_pkg::ST_EMIT;
            mcrq_pkg::ST_EMIT:
            begin
                if (out_free)
                    state_next = mcrq_pkg::ST_IDLE;
            end
            default:
                state_next = mcrq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcrq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs to the cell rows
    // ------------------------------------------------------------------
    always_comb
    begin
        s_tready    = 1'b0;
        q_cmd       = '0;
        cpu_wr_en   = 1'b0;
        q_cmd.mode  = mode_reg;
        q_cmd.pid   = ins_pid_reg;
        q_cmd.prio  = ins_prio_reg;
        unique case (state_reg)
            mcrq_pkg::ST_IDLE:     s_tready     = 1'b1;
            mcrq_pkg::ST_INSERT:   q_cmd.insert = !q_full;
            mcrq_pkg::ST_DISPATCH:
            begin
                q_cmd.pop = !q_empty;
                cpu_wr_en = 1'b1;
            end
            default:               ;
        endcase
    end

    // Dispatch record: head of queue, or idle when empty
    assign cpu_wr_data.busy = !q_empty;
    assign cpu_wr_data.pid  = q_ent[0].pid;
    assign cpu_wr_data.prio = q_ent[0].prio;

    // ------------------------------------------------------------------
    // Event and result registers
    // ------------------------------------------------------------------

    // Result word as it stands when the event is taken
    always_comb
    begin
        res_start = '0;
        if (in_cpu_ok && in_cur.busy)
        begin
            if (in_op == mcrq_pkg::OP_YIELD)
            begin
                res_start.leaving_pid   = in_cur.pid;
                res_start.leaving_state = mcrq_pkg::LEAVE_WAITING;
            end
            else if (in_op == mcrq_pkg::OP_TERMINATE)
            begin
                res_start.leaving_pid   = in_cur.pid;
                res_start.leaving_state = mcrq_pkg::LEAVE_TERMINATED;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg       <= in_op;
            cpu_reg      <= in_cpu;
            cidx_reg     <= in_cidx;
            ins_pid_reg  <= (in_op == mcrq_pkg::OP_WAKE) ? in_pid  : in_cur.pid;
            ins_prio_reg <= (in_op == mcrq_pkg::OP_WAKE) ? in_prio : in_cur.prio;
            res_reg      <= res_start;
        end
        else if (state_reg == mcrq_pkg::ST_INSERT)
        begin
            res_reg.queue_overflow <= q_full;
        end
        else if (state_reg == mcrq_pkg::ST_SCAN)
        begin
            if (scan_done && tok[NUM_CPUS].found && !tok[NUM_CPUS].idle_seen)
            begin
                res_reg.kind       <= mcrq_pkg::KIND_PREEMPT;
                res_reg.target_cpu <= tok[NUM_CPUS].victim;
            end
        end
        else if (state_reg == mcrq_pkg::ST_DISPATCH)
        begin
            res_reg.kind       <= mcrq_pkg::KIND_DISPATCH;
            res_reg.target_cpu <= cpu_reg;
            res_reg.run_pid    <= q_empty ? 8'd0 : q_ent[0].pid;
            res_reg.run_idle   <= q_empty;
            if (mode_reg >= mcrq_pkg::MODE_RR)
            begin
                res_reg.slice_limited <= 1'b1;
                res_reg.slice_length  <= slice_reg;
            end
        end
    end

    // Search wait counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
        end
        else if ((state_reg == mcrq_pkg::ST_SCAN) && !scan_done)
        begin
            scan_cnt_reg <= scan_cnt_reg + SCAN_W'(1);
        end
        else if (state_reg != mcrq_pkg::ST_SCAN)
        begin
            scan_cnt_reg <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if ((state_reg == mcrq_pkg::ST_EMIT) && out_free)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == mcrq_pkg::ST_EMIT) && out_free)
        begin
            m_res_reg <= res_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.kind;
    assign m_tdata  = {7'd0,
                       m_res_reg.queue_overflow,
                       m_res_reg.leaving_state,
                       m_res_reg.leaving_pid,
                       m_res_reg.slice_length,
                       m_res_reg.slice_limited,
                       m_res_reg.run_idle,
                       m_res_reg.run_pid,
                       m_res_reg.target_cpu};

    // ------------------------------------------------------------------
    // Ready-queue cell row, head at cell zero
    // ------------------------------------------------------------------
    assign q_seen[0] = 1'b0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_queue
        if (g == 0)
        begin : g_first
            assign q_left[g] = '0;
        end
        else
        begin : g_inner
            assign q_left[g] = q_ent[g-1];
        end

        if (g == QUEUE_DEPTH - 1)
        begin : g_last
            assign q_right[g] = '0;
        end
        else
        begin : g_body
            assign q_right[g] = q_ent[g+1];
        end

        mcrq_queue_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (q_cmd),
            .left     (q_left[g]),
            .seen_in  (q_seen[g]),
            .right    (q_right[g]),
            .entry    (q_ent[g]),
            .seen_out (q_seen[g+1])
        );
    end

    // ------------------------------------------------------------------
    // CPU cell row with the preemption search chain
    // ------------------------------------------------------------------
    assign tok[0].idle_seen = 1'b0;
    assign tok[0].found     = 1'b0;
    assign tok[0].lowest    = mcrq_pkg::PRIO_CEILING;
    assign tok[0].victim    = 4'd0;

    for (genvar g = 0; g < NUM_CPUS; g++)
    begin : g_cpu
        assign cpu_wr_sel[g] = cpu_wr_en && (cidx_reg == CIDX_W'(g));

        mcrq_cpu_cell #(
            .INDEX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_sel    (cpu_wr_sel[g]),
            .wr_data   (cpu_wr_data),
            .cpus_used (cpus_used),
            .new_prio  (ins_prio_reg),
            .tok_in    (tok[g]),
            .tok_out   (tok[g+1]),
            .entry     (cpu_ent[g])
        );
    end

endmodule

`default_nettype wire

### bench/sched_checker.sv
// ----------------------------------------------------------------------------
// sched_checker: result predictor and comparator for the ready-queue scheduler
// Watches the event, result and register-write channels at the rising edge.
// Every accepted event word updates a private copy of the ready queue and the
// CPU table and queues the result word it must cause. Every accepted result
// word is checked field by field against the oldest queued expectation.
// ----------------------------------------------------------------------------
module sched_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [15:0] s_tdata,   // cpu[3:0], pid[11:4], priority_req[15:12]
    input  wire  [2:0]  s_tuser,   // op[2:0]
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [39:0] m_tdata,   // target_cpu[3:0], run_pid[11:4], run_idle[12],
                                   // slice_limited[13], slice_length[21:14],
                                   // leaving_pid[29:22], leaving_state[31:30],
                                   // queue_overflow[32], zero[39:33]
    input  wire  [1:0]  m_tuser,   // kind[1:0]
    input  wire         cfg_valid,
    input  wire         cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [7:0]  cfg_data,
    output int          mismatches,
    output int          pending_words
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH = mcrq_pkg::QUEUE_DEPTH_DEF;
    localparam int NCPU   = mcrq_pkg::NUM_CPUS_DEF;

    // Register copies
    logic [1:0] sched_mode;
    logic [7:0] slice_cfg;
    logic [4:0] cpus_cfg;

    // Ready queue and running-process table
    logic [7:0] rq_pid [QDEPTH];
    logic [3:0] rq_prio [QDEPTH];
    int         rq_len;
    bit         cpu_busy_tab [NCPU];
    logic [7:0] run_pid_tab [NCPU];
    logic [3:0] run_prio_tab [NCPU];

    // Result words still owed by the block, oldest first
    mcrq_pkg::result_t owed_results [$];
    mcrq_pkg::result_t oldest;

    initial mismatches = 0;

    function automatic void reset_model();
        int i;
        sched_mode = mcrq_pkg::MODE_RESET;
        slice_cfg  = mcrq_pkg::TIME_SLICE_RESET;
        cpus_cfg   = mcrq_pkg::CPU_COUNT_RESET;
        rq_len     = 0;
        for (i = 0; i < NCPU; i++)
            cpu_busy_tab[i] = 1'b0;
        owed_results.delete();
    endfunction

    // Ordered insert; returns 0 when the queue is full and the entry is dropped
    function automatic bit ready_insert(logic [7:0] p, logic [3:0] pr);
        int pos;
        int i;
        bit hit;
        if (rq_len >= QDEPTH)
            return 1'b0;
        pos = rq_len;
        hit = 1'b0;
        for (i = 0; i < rq_len; i++) begin
            if (!hit && sched_mode == mcrq_pkg::MODE_PID && rq_pid[i] > p) begin
                pos = i;
                hit = 1'b1;
            end
            // newcomer goes ahead of equal priorities
            if (!hit && sched_mode == mcrq_pkg::MODE_PRIO && rq_prio[i] <= pr) begin
                pos = i;
                hit = 1'b1;
            end
        end
        for (i = rq_len; i > pos; i--) begin
            rq_pid[i]  = rq_pid[i - 1];
            rq_prio[i] = rq_prio[i - 1];
        end
        rq_pid[pos]  = p;
        rq_prio[pos] = pr;
        rq_len++;
        return 1'b1;
    endfunction

    // Pop the head onto CPU c, or hand it the idle process
    function automatic mcrq_pkg::result_t dispatch_to(logic [3:0] c, mcrq_pkg::result_t r);
        int i;
        r.kind       = mcrq_pkg::KIND_DISPATCH;
        r.target_cpu = c;
        if (rq_len > 0) begin
            cpu_busy_tab[c] = 1'b1;
            run_pid_tab[c]  = rq_pid[0];
            run_prio_tab[c] = rq_prio[0];
            for (i = 1; i < rq_len; i++) begin
                rq_pid[i - 1]  = rq_pid[i];
                rq_prio[i - 1] = rq_prio[i];
            end
            rq_len--;
            r.run_pid = run_pid_tab[c];
        end else begin
            cpu_busy_tab[c] = 1'b0;
            r.run_idle      = 1'b1;
        end
        // round robin and its alias code carry a slice
        if (sched_mode >= mcrq_pkg::MODE_RR) begin
            r.slice_limited = 1'b1;
            r.slice_length  = slice_cfg;
        end
        return r;
    endfunction

    function automatic mcrq_pkg::result_t predict_event(logic [2:0] op, logic [3:0] c,
                                                        logic [7:0] p, logic [3:0] pr);
        mcrq_pkg::result_t r;
        int         n;
        int         i;
        bit         idle_seen;
        bit         hit;
        logic [3:0] lowest;
        logic [3:0] victim;
        r = '0;
        n = (cpus_cfg < NCPU) ? int'(cpus_cfg) : NCPU;

        if (op == mcrq_pkg::OP_WAKE) begin
            if (!ready_insert(p, pr)) begin
                r.queue_overflow = 1'b1;
                return r;
            end
            if (sched_mode == mcrq_pkg::MODE_PRIO) begin
                idle_seen = 1'b0;
                hit       = 1'b0;
                lowest    = mcrq_pkg::PRIO_CEILING;
                victim    = '0;
                // scan stops at the first idle CPU
                for (i = 0; i < n; i++) begin
                    if (!idle_seen) begin
                        if (!cpu_busy_tab[i])
                            idle_seen = 1'b1;
                        else if (pr > run_prio_tab[i] && run_prio_tab[i] < lowest) begin
                            lowest = run_prio_tab[i];
                            victim = i[3:0];
                            hit    = 1'b1;
                        end
                    end
                end
                if (hit && !idle_seen) begin
                    r.kind       = mcrq_pkg::KIND_PREEMPT;
                    r.target_cpu = victim;
                end
            end
            return r;
        end

        // unknown op or CPU not in use: empty word, no state change
        if (op > mcrq_pkg::OP_IDLE_REQ || int'(c) >= n)
            return r;

        if (op == mcrq_pkg::OP_PREEMPT) begin
            if (cpu_busy_tab[c] && !ready_insert(run_pid_tab[c], run_prio_tab[c]))
                r.queue_overflow = 1'b1;
        end else if (op == mcrq_pkg::OP_YIELD || op == mcrq_pkg::OP_TERMINATE) begin
            if (cpu_busy_tab[c]) begin
                r.leaving_pid   = run_pid_tab[c];
                r.leaving_state = (op == mcrq_pkg::OP_YIELD) ? mcrq_pkg::LEAVE_WAITING
                                                             : mcrq_pkg::LEAVE_TERMINATED;
            end
        end
        return dispatch_to(c, r);
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    task automatic check_word(mcrq_pkg::result_t e);
        check_field("kind",           e.kind,           m_tuser);
        check_field("target_cpu",     e.target_cpu,     m_tdata[3:0]);
        check_field("run_pid",        e.run_pid,        m_tdata[11:4]);
        check_field("run_idle",       e.run_idle,       m_tdata[12]);
        check_field("slice_limited",  e.slice_limited,  m_tdata[13]);
        check_field("slice_length",   e.slice_length,   m_tdata[21:14]);
        check_field("leaving_pid",    e.leaving_pid,    m_tdata[29:22]);
        check_field("leaving_state",  e.leaving_state,  m_tdata[31:30]);
        check_field("queue_overflow", e.queue_overflow, m_tdata[32]);
        check_field("padding",        '0,               m_tdata[39:33]);
    endtask

    // Channel monitor
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            reset_model();
            pending_words = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    mcrq_pkg::CFG_MODE:       sched_mode = cfg_data[1:0];
                    mcrq_pkg::CFG_TIME_SLICE: slice_cfg  = cfg_data;
                    mcrq_pkg::CFG_CPU_COUNT:  cpus_cfg   = cfg_data[4:0];
                    default:                  ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %0h/%0h",
                             $time, m_tuser, m_tdata);
                    mismatches++;
                end else begin
                    oldest = owed_results.pop_front();
                    check_word(oldest);
                end
            end
            if (s_tvalid && s_tready)
                owed_results.push_back(predict_event(s_tuser, s_tdata[3:0],
                                                     s_tdata[11:4], s_tdata[15:12]));
            pending_words = owed_results.size();
        end
    end

endmodule

### bench/multi_cpu_ready_queue_scheduler_tb.sv
// ----------------------------------------------------------------------------
// multi_cpu_ready_queue_scheduler_tb: stimulus and verdict for the scheduler
// Two directed runs over the field extremes and corner cases, then eight random
// phases under different mode, slice and CPU-count settings with idle and
// stall patterns on both streams, including one long output back-pressure.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module multi_cpu_ready_queue_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Mode code 3 behaves as round robin
    localparam logic [1:0] MODE_RR_ALT = 2'd3;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 160;
    localparam int BLOCK_ITEMS  = 20;
    localparam int SETTLE       = mcrq_pkg::NUM_CPUS_DEF + 10;
    localparam int HOLD_CYCLES  = 300;
    // worst gap: priority wake-up, long receiver stall runs, or the hold-off
    localparam int STALL_LIMIT  = 4000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // cpu[3:0], pid[11:4], priority_req[15:12]
    logic [2:0]  s_tuser;    // op[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;    // target_cpu[3:0], run_pid[11:4], run_idle[12],
                             // slice_limited[13], slice_length[21:14],
                             // leaving_pid[29:22], leaving_state[31:30],
                             // queue_overflow[32], zero[39:33]
    logic [1:0]  m_tuser;    // kind[1:0]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    int          mismatches;
    int          pending_words;
    int          tx_idle_pct = 10;
    int          rx_idle_pct = 53;
    logic        hold_go = 1'b0;
    logic        rx_hold = 1'b0;
    int          stall_cycles = 0;

    multi_cpu_ready_queue_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sched_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending_words (pending_words)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result-side ready: random stalls, forced low during the hold-off
    always @(negedge clk)
    begin
        m_tready = !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Long receiver hold-off so the block fills and stalls its input
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // One event word, with random idle cycles ahead of it
    task automatic send_event(logic [2:0] op, logic [3:0] c, logic [7:0] p,
                              logic [3:0] pr);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {pr, p, c};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_regs(logic [1:0] mode_v, logic [7:0] slice_v, logic [7:0] cpus_v);
        write_reg(mcrq_pkg::CFG_MODE, mode_v);
        write_reg(mcrq_pkg::CFG_TIME_SLICE, slice_v);
        write_reg(mcrq_pkg::CFG_CPU_COUNT, cpus_v);
    endtask

    // Stop offering and let every owed word come out
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_words != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Random event; flavor 1 favors wake-ups, flavor 2 favors dispatches
    task automatic random_event(int flavor, int ncpu);
        int         roll;
        int         wake_pct;
        logic [2:0] op;
        logic [3:0] c;
        wake_pct = (flavor == 1) ? 85 : (flavor == 2) ? 10 : 40;
        roll = $urandom_range(0, 99);
        if (roll < wake_pct)
            op = mcrq_pkg::OP_WAKE;
        else if (roll >= 97)
            op = mcrq_pkg::OP_IDLE_REQ + 3'($urandom_range(1, 3));
        else
            op = 3'($urandom_range(mcrq_pkg::OP_PREEMPT, mcrq_pkg::OP_IDLE_REQ));
        if ($urandom_range(0, 9) == 0)
            c = 4'($urandom_range(0, 15));
        else
            c = 4'($urandom_range(0, ncpu - 1));
        send_event(op, c, 8'($urandom), 4'($urandom_range(0, 15)));
    endtask

    initial
    begin
        logic [1:0] mode_seq [PHASES];
        int         cpu_seq [PHASES];
        logic [7:0] slice_v;
        int         ph;
        int         k;
        int         flavor;

        mode_seq = '{mcrq_pkg::MODE_PID, mcrq_pkg::MODE_PRIO, mcrq_pkg::MODE_RR, MODE_RR_ALT,
                     mcrq_pkg::MODE_PRIO, mcrq_pkg::MODE_PID, mcrq_pkg::MODE_PRIO,
                     mcrq_pkg::MODE_RR};
        cpu_seq  = '{1, 16, 4, 16, 2, 8, 16, 3};

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: priority mode on two CPUs, zero slice
        set_regs(mcrq_pkg::MODE_PRIO, 8'd0, 8'd2);
        send_event(mcrq_pkg::OP_YIELD,     4'd0,  8'd0,   4'd0);   // yield of an idle CPU
        send_event(mcrq_pkg::OP_PREEMPT,   4'd1,  8'd0,   4'd0);   // preempt of an idle CPU
        send_event(mcrq_pkg::OP_WAKE,      4'd0,  8'd0,   4'd0);
        send_event(mcrq_pkg::OP_WAKE,      4'd15, 8'd255, 4'd15);
        send_event(mcrq_pkg::OP_IDLE_REQ,  4'd0,  8'd0,   4'd0);
        send_event(mcrq_pkg::OP_IDLE_REQ,  4'd1,  8'd0,   4'd0);
        send_event(mcrq_pkg::OP_WAKE,      4'd0,  8'd7,   4'd12);  // preempts the low CPU
        send_event(mcrq_pkg::OP_PREEMPT,   4'd1,  8'd0,   4'd0);
        send_event(mcrq_pkg::OP_WAKE,      4'd0,  8'd9,   4'd15);  // both CPUs above ceiling
        send_event(mcrq_pkg::OP_IDLE_REQ,  4'd0,  8'd0,   4'd0);   // overwrites a busy CPU
        send_event(mcrq_pkg::OP_TERMINATE, 4'd1,  8'd0,   4'd0);
        send_event(mcrq_pkg::OP_YIELD,     4'd0,  8'd0,   4'd0);
        send_event(mcrq_pkg::OP_IDLE_REQ + 3'd1, 4'd0, 8'd0, 4'd0);  // unknown ops
        send_event(mcrq_pkg::OP_IDLE_REQ + 3'd2, 4'd0, 8'd0, 4'd0);
        send_event(mcrq_pkg::OP_IDLE_REQ + 3'd3, 4'd15, 8'd255, 4'd15);
        send_event(mcrq_pkg::OP_YIELD,     4'd15, 8'd0,   4'd0);   // CPUs out of use
        send_event(mcrq_pkg::OP_PREEMPT,   4'd2,  8'd0,   4'd0);
        drain();

        // Directed: alias round-robin code, widest slice, all CPUs
        set_regs(MODE_RR_ALT, 8'd255, 8'd16);
        send_event(mcrq_pkg::OP_WAKE,      4'd0,  8'h55,  4'd10);
        send_event(mcrq_pkg::OP_WAKE,      4'd0,  8'hAA,  4'd5);
        send_event(mcrq_pkg::OP_IDLE_REQ,  4'd15, 8'd0,   4'd0);
        send_event(mcrq_pkg::OP_PREEMPT,   4'd15, 8'd0,   4'd0);
        send_event(mcrq_pkg::OP_TERMINATE, 4'd15, 8'd0,   4'd0);
        send_event(mcrq_pkg::OP_YIELD,     4'd0,  8'd0,   4'd0);
        drain();

        // Random phases
        for (ph = 0; ph < PHASES; ph++) begin
            if (ph < 3) begin
                tx_idle_pct = 10;
                rx_idle_pct = 53;
            end else if (ph < 6) begin
                tx_idle_pct = 53;
                rx_idle_pct = 10;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (ph)
                0:       slice_v = 8'd1;
                1:       slice_v = 8'd255;
                2:       slice_v = 8'd0;
                default: slice_v = 8'($urandom_range(0, 255));
            endcase
            set_regs(mode_seq[ph], slice_v, 8'(cpu_seq[ph]));
            flavor = 0;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (k % BLOCK_ITEMS == 0)
                    flavor = $urandom_range(0, 2);
                if (ph == 1 && k == 40)
                    hold_go = 1'b1;
                random_event(flavor, cpu_seq[ph]);
            end
            drain();
        end

        if (mismatches == 0 && pending_words == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
